// ----- hw/rtl/pqds_pkg.sv -----
// ----------------------------------------------------------------------------
// pqds_pkg
// shared types, constants and helpers of the product-quantization scan core
// ----------------------------------------------------------------------------
package pqds_pkg;

	localparam int SUBSPACES = 8;
	localparam int CODEWORDS = 256;
	localparam int KEEP_MAX  = 16;

	localparam int SUB_W  = 3;
	localparam int CW_W   = 8;
	localparam int VAL_W  = 16;
	localparam int TAG_W  = 32;
	localparam int CODE_W = 64;
	localparam int DIST_W = 19;
	localparam int RANK_W = 4;
	localparam int KC_W   = 5;
	localparam int SLOT_W = $clog2(KEEP_MAX);
	localparam int CNT_W  = $clog2(KEEP_MAX + 1);
	localparam int SUBA_W = (SUBSPACES > 1) ? $clog2(SUBSPACES) : 1;
	localparam int CWA_W  = $clog2(CODEWORDS);
	localparam int TADDR_W = $clog2(SUBSPACES * CODEWORDS);

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_START  = 2'd1,
		CMD_SCORE  = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCORE,
		ST_SUM,
		ST_FIND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [SUB_W-1:0]  table_subspace;
		logic [CW_W-1:0]   table_codeword;
		logic [VAL_W-1:0]  table_value;
		logic [TAG_W-1:0]  entry_tag;
		logic [CODE_W-1:0] entry_codes;
	} item_t;

	typedef struct packed {
		logic [TAG_W-1:0]  result_tag;
		logic [DIST_W-1:0] result_distance;
		logic [RANK_W-1:0] result_rank;
		logic              result_last;
		logic              result_empty;
	} result_t;

	// one kept slot with its ordering key
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [31:0]       arrival;
		logic [SLOT_W-1:0] slot;
	} key_t;

	// true when a orders strictly after b
	function automatic logic key_after(key_t a, key_t b);
		if (a.distance != b.distance) return a.distance > b.distance;
		if (a.arrival != b.arrival) return a.arrival > b.arrival;
		return a.slot > b.slot;
	endfunction

endpackage

// ----- hw/rtl/pq_distance_scan_topk_core.sv -----
// ----------------------------------------------------------------------------
// pq_distance_scan_topk_core
// product-quantization distance scan keeping the k nearest entries
// ----------------------------------------------------------------------------
// write and start leave busy low; score is busy in its score, sum and update states
// while the list fills, and in a find scan of every kept slot as well when full,
// one kept slot examined per cycle; finish scans every kept slot per emitted word
// (one slot scan per rank), or gives the single empty word when none is kept;
// words are strobed, the receiver cannot stall; reset clears the kept list and
// arrival counter and sets keep_count to 10; the distance table is undefined until written
module pq_distance_scan_topk_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pqds_pkg::item_t      item,
	output logic                 result_valid,
	output pqds_pkg::result_t    result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [pqds_pkg::KC_W-1:0] cfg_data
);
	localparam int SW = pqds_pkg::SLOT_W;
	localparam int CW = pqds_pkg::CNT_W;

	pqds_pkg::state_t state_q, state_d;
	logic [pqds_pkg::KC_W-1:0] keep_count_q;
	logic [CW-1:0] limit;

	// kept list
	logic [pqds_pkg::DIST_W-1:0] kdist_q [pqds_pkg::KEEP_MAX];
	logic [pqds_pkg::TAG_W-1:0]  ktag_q  [pqds_pkg::KEEP_MAX];
	logic [31:0]                 karr_q  [pqds_pkg::KEEP_MAX];
	logic [CW-1:0]               ktotal_q;
	logic [31:0]                 arrival_q;

	logic [pqds_pkg::TAG_W-1:0] tag_q;
	logic [CW-1:0]  scan_q;          // slot being scanned
	pqds_pkg::key_t best_q;          // running extreme of scan
	logic           best_ok_q;
	pqds_pkg::key_t prev_q;          // last emitted key (finish)
	logic [CW-1:0]  rank_q, emit_n_q;
	logic [pqds_pkg::DIST_W-1:0] total_s1;
	logic [pqds_pkg::DIST_W-1:0] score_q;   // total of the word being scored

	// lanes: one table slice per subspace
	logic [pqds_pkg::VAL_W-1:0] lane_value [pqds_pkg::SUBSPACES];
	logic table_we;
	assign table_we = start && !busy && item.command == pqds_pkg::CMD_WRITE
		&& {1'b0, item.table_subspace} < (pqds_pkg::SUB_W+1)'(pqds_pkg::SUBSPACES)
		&& {1'b0, item.table_codeword} < (pqds_pkg::CW_W+1)'(pqds_pkg::CODEWORDS);

	for (genvar m = 0; m < pqds_pkg::SUBSPACES; m++) begin : g_lane
		pqds_lane u_lane (
			.clk   (clk),
			.we    (table_we && item.table_subspace == pqds_pkg::SUB_W'(m)),
			.waddr (pqds_pkg::CWA_W'(item.table_codeword)),
			.wdata (item.table_value),
			.code  (item.entry_codes[8*m +: 8]),
			.value (lane_value[m])
		);
	end

	pqds_merge u_merge (.clk(clk), .lane_value(lane_value), .total_s1(total_s1));

	// effective limit 1..KEEP_MAX
	always_comb begin
		if (keep_count_q == '0) limit = CW'(1);
		else if ({1'b0, keep_count_q} > (pqds_pkg::KC_W+1)'(pqds_pkg::KEEP_MAX))
			limit = CW'(pqds_pkg::KEEP_MAX);
		else limit = CW'(keep_count_q);
	end

	assign busy      = state_q != pqds_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;

	// key of the slot under scan
	pqds_pkg::key_t cur_key;
	logic [SW-1:0]  cur_slot;
	assign cur_slot = scan_q[SW-1:0];
	assign cur_key  = '{distance: kdist_q[cur_slot], arrival: karr_q[cur_slot], slot: cur_slot};
	logic scan_end;
	assign scan_end = scan_q + CW'(1) >= ktotal_q;

	// finish picks the smallest key that orders after the previous one
	logic cand_ok, take;
	always_comb begin
		cand_ok = (rank_q == '0) || pqds_pkg::key_after(cur_key, prev_q);
		if (state_q == pqds_pkg::ST_FIND)
			take = !best_ok_q || pqds_pkg::key_after(cur_key, best_q);
		else
			take = cand_ok && (!best_ok_q || pqds_pkg::key_after(best_q, cur_key));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pqds_pkg::ST_IDLE: begin
				if (start) begin
					case (item.command)
						pqds_pkg::CMD_SCORE:  state_d = pqds_pkg::ST_SCORE;
						pqds_pkg::CMD_FINISH: state_d = pqds_pkg::ST_EMIT;
						default:              state_d = pqds_pkg::ST_IDLE;
					endcase
				end
			end
			pqds_pkg::ST_SCORE: state_d = pqds_pkg::ST_SUM;
			pqds_pkg::ST_SUM:
				state_d = (ktotal_q < limit) ? pqds_pkg::ST_UPDATE : pqds_pkg::ST_FIND;
			pqds_pkg::ST_FIND: if (scan_end) state_d = pqds_pkg::ST_UPDATE;
			pqds_pkg::ST_UPDATE: state_d = pqds_pkg::ST_IDLE;
			pqds_pkg::ST_EMIT:
				if (ktotal_q == '0 || (scan_end && rank_q + CW'(1) >= emit_n_q))
					state_d = pqds_pkg::ST_IDLE;
			default: state_d = pqds_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		result_valid = 1'b0;
		result = '0;
		if (state_q == pqds_pkg::ST_EMIT) begin
			if (ktotal_q == '0) begin
				result_valid = 1'b1;
				result.result_last  = 1'b1;
				result.result_empty = 1'b1;
			end else if (scan_end) begin
				result_valid = 1'b1;
				result.result_tag = take ? ktag_q[cur_slot] : ktag_q[best_q.slot];
				result.result_distance = take ? cur_key.distance : best_q.distance;
				result.result_rank = pqds_pkg::RANK_W'(rank_q);
				result.result_last = rank_q + CW'(1) >= emit_n_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pqds_pkg::ST_IDLE;
			keep_count_q <= pqds_pkg::KC_W'(10);
			ktotal_q     <= '0;
			arrival_q    <= '0;
			scan_q       <= '0;
			best_ok_q    <= 1'b0;
			rank_q       <= '0;
			emit_n_q     <= '0;
			tag_q        <= '0;
			score_q      <= '0;
			best_q       <= '0;
			prev_q       <= '0;
			for (int i = 0; i < pqds_pkg::KEEP_MAX; i++) begin
				kdist_q[i] <= '0;
				ktag_q[i]  <= '0;
				karr_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) keep_count_q <= cfg_data;
			case (state_q)
				pqds_pkg::ST_IDLE: begin
					scan_q    <= '0;
					best_ok_q <= 1'b0;
					rank_q    <= '0;
					tag_q     <= item.entry_tag;
					emit_n_q  <= (ktotal_q > limit) ? limit : ktotal_q;
					if (start && item.command == pqds_pkg::CMD_START) begin
						ktotal_q  <= '0;
						arrival_q <= '0;
						for (int i = 0; i < pqds_pkg::KEEP_MAX; i++) begin
							kdist_q[i] <= '0;
							ktag_q[i]  <= '0;
							karr_q[i]  <= '0;
						end
					end
				end
				// hold the lane sum, the lanes move on with the input port
				pqds_pkg::ST_SUM: score_q <= total_s1;
				pqds_pkg::ST_FIND: begin
					if (take) begin
						best_q    <= cur_key;
						best_ok_q <= 1'b1;
					end
					scan_q <= scan_q + CW'(1);
				end
				pqds_pkg::ST_UPDATE: begin
					arrival_q <= arrival_q + 32'd1;
					if (ktotal_q < limit) begin
						kdist_q[ktotal_q[SW-1:0]] <= score_q;
						ktag_q[ktotal_q[SW-1:0]]  <= tag_q;
						karr_q[ktotal_q[SW-1:0]]  <= arrival_q;
						ktotal_q <= ktotal_q + CW'(1);
					end else if (score_q < best_q.distance) begin
						kdist_q[best_q.slot] <= score_q;
						ktag_q[best_q.slot]  <= tag_q;
						karr_q[best_q.slot]  <= arrival_q;
					end
				end
				pqds_pkg::ST_EMIT: begin
					if (scan_end) begin
						prev_q    <= take ? cur_key : best_q;
						best_ok_q <= 1'b0;
						scan_q    <= '0;
						rank_q    <= rank_q + CW'(1);
					end else begin
						if (take) begin
							best_q    <= cur_key;
							best_ok_q <= 1'b1;
						end
						scan_q <= scan_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- hw/rtl/pqds_ram.sv -----
// ----------------------------------------------------------------------------
// pqds_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module pqds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/pqds_lane.sv -----
// ----------------------------------------------------------------------------
// pqds_lane
// one subspace lane: its slice of the distance table and code lookup
// ----------------------------------------------------------------------------
module pqds_lane (
	input  logic                        clk,
	input  logic                        we,
	input  logic [pqds_pkg::CWA_W-1:0]  waddr,
	input  logic [pqds_pkg::VAL_W-1:0]  wdata,
	input  logic [pqds_pkg::CW_W-1:0]   code,
	output logic [pqds_pkg::VAL_W-1:0]  value
);
	logic [pqds_pkg::CWA_W-1:0] raddr;

	// codes beyond the table saturate to the last codeword
	always_comb begin
		if ({1'b0, code} >= (pqds_pkg::CW_W+1)'(pqds_pkg::CODEWORDS))
			raddr = pqds_pkg::CWA_W'(pqds_pkg::CODEWORDS - 1);
		else
			raddr = pqds_pkg::CWA_W'(code);
	end

	pqds_ram #(.WIDTH(pqds_pkg::VAL_W), .DEPTH(pqds_pkg::CODEWORDS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (value)
	);
endmodule

// ----- hw/rtl/pqds_merge.sv -----
// ----------------------------------------------------------------------------
// pqds_merge
// adds the lane values into one registered total
// ----------------------------------------------------------------------------
module pqds_merge (
	input  logic                        clk,
	input  logic [pqds_pkg::VAL_W-1:0]  lane_value [pqds_pkg::SUBSPACES],
	output logic [pqds_pkg::DIST_W-1:0] total_s1
);
	logic [pqds_pkg::DIST_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int m = 0; m < pqds_pkg::SUBSPACES; m++)
			sum = sum + pqds_pkg::DIST_W'(lane_value[m]);
	end

	always_ff @(posedge clk) begin
		total_s1 <= sum;
	end
endmodule
